### rtl/core/bdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// shared types and constants for the bounded deque core
// ----------------------------------------------------------------------------
package bdq_pkg;

   // field widths of the stream words
   localparam int OPCODE_W    = 3;
   localparam int POS_W       = 5;
   localparam int VALUE_W     = 32;
   localparam int COUNT_OUT_W = 5;
   localparam int STATUS_W    = 2;
   localparam int BOUND_W     = 4;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_INSERT     = 3'd4,
      OP_DELETE     = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_DONE    = 2'd0,
      STS_IGNORED = 2'd1,
      STS_DROPPED = 2'd2
   } rsp_status_type;

   // occupancy of the response register
   typedef enum logic {
      RSP_EMPTY = 1'b0,
      RSP_FULL  = 1'b1
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture result word
      logic do_insert;  // shift tail right and place new entry
      logic do_remove;  // shift tail left over removed entry
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic ins_ok;     // current word is a legal push or insert
      logic rem_ok;     // current word is a legal pop or delete
   } dp_sts_type;

endpackage
`default_nettype wire

### rtl/core/bdq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl
// handshake controller: tracks the response register and issues commands
// ----------------------------------------------------------------------------
module bdq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output      logic                 req_tready,
   output      logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire bdq_pkg::dp_sts_type  sts,
   output      bdq_pkg::dp_cmd_type  cmd
);

   bdq_pkg::ctrl_state_type state_ff, state_in;
   logic accept;

   assign req_tready = (state_ff == bdq_pkg::RSP_EMPTY) || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdq_pkg::RSP_EMPTY: begin
            if (accept) state_in = bdq_pkg::RSP_FULL;
         end
         bdq_pkg::RSP_FULL: begin
            if (!accept && rsp_tready) state_in = bdq_pkg::RSP_EMPTY;
         end
         default: state_in = bdq_pkg::RSP_EMPTY;
      endcase
   end

   // outputs
   always_comb begin
      rsp_tvalid    = 1'b0;
      cmd.load      = accept;
      cmd.do_insert = accept && sts.ins_ok;
      cmd.do_remove = accept && sts.rem_ok;
      case (state_ff)
         bdq_pkg::RSP_EMPTY: rsp_tvalid = 1'b0;
         bdq_pkg::RSP_FULL:  rsp_tvalid = 1'b1;
         default:            rsp_tvalid = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdq_pkg::RSP_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/bdq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_datapath
// row of entry cells with parallel shift, count, bound register, result regs
// ----------------------------------------------------------------------------
module bdq_datapath #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [bdq_pkg::BOUND_W-1:0]         csr_wr_data,
   input  wire bdq_pkg::op_type                     in_op,
   input  wire logic [bdq_pkg::POS_W-1:0]           in_position,
   input  wire logic [bdq_pkg::VALUE_W-1:0]         in_value,
   input  wire bdq_pkg::dp_cmd_type                 cmd,
   output      bdq_pkg::dp_sts_type                 sts,
   output      logic [bdq_pkg::VALUE_W-1:0]         out_popped_value,
   output      logic                                out_popped_valid,
   output      logic [bdq_pkg::COUNT_OUT_W-1:0]     out_entry_count,
   output      bdq_pkg::rsp_status_type             out_status
);

   localparam int CW  = $clog2(DEPTH + 1);
   localparam int AW  = $clog2(DEPTH);
   localparam int VW  = bdq_pkg::VALUE_W;
   localparam int KW0 = (CW > bdq_pkg::POS_W) ? CW : bdq_pkg::POS_W;
   localparam int KW  = KW0 + 1;

   logic [WIDTH-1:0] cells_ff [DEPTH];
   logic [WIDTH-1:0] cells_in [DEPTH];
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [bdq_pkg::BOUND_W-1:0] bound_ff;

   logic [bdq_pkg::VALUE_W-1:0] popped_value_ff, popped_value_in;
   logic                        popped_valid_ff, popped_valid_in;
   logic [bdq_pkg::COUNT_OUT_W-1:0] entry_count_ff;
   bdq_pkg::rsp_status_type     status_ff, status_in;

   logic [KW-1:0]    cnt_ext, pos_ext, idx, lim, grown, cnt_next_ext;
   logic [AW-1:0]    back_idx;
   logic [WIDTH-1:0] val_w, pop_cell;
   logic [bdq_pkg::VALUE_W-1:0] pop_word;
   logic             is_pop, cut;

   // value width adaption
   assign val_w    = WIDTH'(in_value);
   assign pop_word = VW'(pop_cell);

   assign cnt_ext  = KW'(cnt_ff);
   assign pos_ext  = KW'(in_position);
   assign back_idx = cnt_ext[AW-1:0] - AW'(1);

   // active limit: bound plus one, or the full row when zero or too large
   always_comb begin
      lim = KW'(bound_ff) + KW'(1);
      if (bound_ff == '0 || lim > KW'(DEPTH)) lim = KW'(DEPTH);
   end

   // decode and range check
   always_comb begin
      sts.ins_ok = 1'b0;
      sts.rem_ok = 1'b0;
      idx        = '0;
      is_pop     = 1'b0;
      case (in_op)
         bdq_pkg::OP_PUSH_BACK: begin
            sts.ins_ok = 1'b1;
            idx        = cnt_ext;
         end
         bdq_pkg::OP_PUSH_FRONT: begin
            sts.ins_ok = 1'b1;
         end
         bdq_pkg::OP_POP_BACK: begin
            sts.rem_ok = (cnt_ff != '0);
            idx        = cnt_ext - KW'(1);
            is_pop     = 1'b1;
         end
         bdq_pkg::OP_POP_FRONT: begin
            sts.rem_ok = (cnt_ff != '0);
            is_pop     = 1'b1;
         end
         bdq_pkg::OP_INSERT: begin
            sts.ins_ok = (pos_ext <= cnt_ext);
            idx        = pos_ext;
         end
         bdq_pkg::OP_DELETE: begin
            sts.rem_ok = (pos_ext < cnt_ext);
            idx        = pos_ext;
         end
         default: begin
            sts.ins_ok = 1'b0;
         end
      endcase
   end

   // per-cell next value
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cells_in[i] = cells_ff[i];
         if (cmd.do_insert) begin
            if (KW'(i) == idx) cells_in[i] = val_w;
            if (i > 0 && KW'(i) > idx) cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
         end else if (cmd.do_remove) begin
            if (i < DEPTH - 1 && KW'(i) >= idx)
               cells_in[i] = cells_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   // count and result word
   always_comb begin
      grown        = cnt_ext + KW'(1);
      cut          = grown > lim;
      cnt_next_ext = cnt_ext;
      status_in    = bdq_pkg::STS_IGNORED;
      if (cmd.do_insert) begin
         cnt_next_ext = cut ? lim : grown;
         status_in    = cut ? bdq_pkg::STS_DROPPED : bdq_pkg::STS_DONE;
      end else if (cmd.do_remove) begin
         cnt_next_ext = cnt_ext - KW'(1);
         status_in    = bdq_pkg::STS_DONE;
      end
      cnt_in = cnt_next_ext[CW-1:0];

      pop_cell        = (in_op == bdq_pkg::OP_POP_FRONT) ? cells_ff[0] : cells_ff[back_idx];
      popped_valid_in = cmd.do_remove && is_pop;
      popped_value_in = popped_valid_in ? pop_word : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         bound_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (csr_wr_en) bound_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         cells_ff[i] <= cells_in[i];
      end
      if (cmd.load) begin
         popped_value_ff <= popped_value_in;
         popped_valid_ff <= popped_valid_in;
         entry_count_ff  <= cnt_next_ext[bdq_pkg::COUNT_OUT_W-1:0];
         status_ff       <= status_in;
      end
   end

   assign out_popped_value = popped_value_ff;
   assign out_popped_valid = popped_valid_ff;
   assign out_entry_count  = entry_count_ff;
   assign out_status       = status_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      KW'(cnt_ff) <= KW'(DEPTH))
      else $error("entry count above depth");

   a_one_shift: assert property (@(posedge clock) disable iff (reset)
      !(cmd.do_insert && cmd.do_remove))
      else $error("insert and remove in the same cycle");

   a_insert_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.do_insert |=> cnt_ff != '0)
      else $error("queue empty after insert");

   a_remove_dec: assert property (@(posedge clock) disable iff (reset)
      cmd.do_remove |=> cnt_ff == $past(cnt_ff) - CW'(1))
      else $error("remove did not decrement count");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.load |=> $stable(cnt_ff))
      else $error("count changed without an accepted word");

endmodule
`default_nettype wire

### rtl/core/bounded_deque_with_indexed_insert_core.sv
`timescale 1ns / 1ps
`default_nettype none
// the result word is registered and valid in the cycle after its request word is accepted
// throughput: one word per cycle when not back-pressured; cells shift in one parallel step
// a new request is taken while the previous result waits, if the result is taken too
// reset (synchronous, active high) clears the count, the bound register and rsp_tvalid
// entry cells are not cleared; only cells below the count are ever read
// ----------------------------------------------------------------------------
// bounded_deque_with_indexed_insert_core
// double-ended queue with indexed insert/delete and a programmable bound
// ----------------------------------------------------------------------------
module bounded_deque_with_indexed_insert_core #(
   parameter int DEPTH = 16,  // number of entry cells
   parameter int WIDTH = 32   // bits stored per entry
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration: highest index bound
   input  wire logic                                csr_wr_en,
   input  wire logic [bdq_pkg::BOUND_W-1:0]         csr_wr_data,
   // request channel
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [bdq_pkg::REQ_TDATA_W-1:0]     req_tdata,  // position[4:0], value[36:5]
   input  wire logic [bdq_pkg::OPCODE_W-1:0]        req_tuser,  // opcode[2:0]
   // response channel
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [bdq_pkg::RSP_TDATA_W-1:0]     rsp_tdata,  // popped_value[31:0],
                                                                // entry_count[36:32],
                                                                // status[38:37], zero pad
   output      logic                                rsp_tuser   // popped_valid
);

   bdq_pkg::dp_cmd_type cmd;
   bdq_pkg::dp_sts_type sts;

   logic [bdq_pkg::VALUE_W-1:0]     popped_value;
   logic                            popped_valid;
   logic [bdq_pkg::COUNT_OUT_W-1:0] entry_count;
   bdq_pkg::rsp_status_type         status;

   // handshake and command sequencing
   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // cell row, count and result registers
   bdq_datapath #(
      .DEPTH (DEPTH),
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .in_op            (bdq_pkg::op_type'(req_tuser)),
      .in_position      (req_tdata[bdq_pkg::POS_W-1:0]),
      .in_value         (req_tdata[bdq_pkg::POS_W +: bdq_pkg::VALUE_W]),
      .cmd              (cmd),
      .sts              (sts),
      .out_popped_value (popped_value),
      .out_popped_valid (popped_valid),
      .out_entry_count  (entry_count),
      .out_status       (status)
   );

   // pack the response word, highest field first
   assign rsp_tdata = {1'b0, status, entry_count, popped_value};
   assign rsp_tuser = popped_valid;

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bounded deque core with indexed insert/delete
//
// a mirror of the deque inside a small scoreboard class predicts one
// response word per request word; every accepted response is compared
// field by field with the oldest prediction.
// stimulus is a short directed opening (empty pops, bad indexes, spare
// opcodes, full-queue drops, bound lowered under the count), then phases of
// random words under a sweep of bound settings, with random gaps on both
// channels and long receiver hold-offs that back the core up.
// ----------------------------------------------------------------------------
module tb;

   localparam int CELLS          = 16;    // entry cells in the core
   localparam int PHASES         = 18;
   localparam int SEGMENT_WORDS  = 35;    // words per traffic segment
   localparam int SEGMENTS       = 3;     // segments per phase
   localparam int RX_HOLD_CYCLES = 150;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
   localparam int MAX_REPORTS    = 50;

   // opcodes the core has no operation for
   localparam logic [bdq_pkg::OPCODE_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [bdq_pkg::OPCODE_W-1:0] OP_SPARE_B = 3'd7;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } traffic_mix_type;

   typedef struct {
      logic [bdq_pkg::VALUE_W-1:0]     value;
      logic                            valid;
      logic [bdq_pkg::COUNT_OUT_W-1:0] count;
      bdq_pkg::rsp_status_type         status;
   } deque_response_type;

   // mirror of the deque plus the words still owed by the core
   class deque_scoreboard;
      logic [bdq_pkg::VALUE_W-1:0] mirror_cells [CELLS];
      int                          mirror_count;
      logic [bdq_pkg::BOUND_W-1:0] mirror_bound;
      deque_response_type          awaited_responses [$];
      int unsigned                 mismatches;
      int unsigned                 pops_seen;
      int unsigned                 drops_seen;
      int unsigned                 ignores_seen;

      function new();
         mirror_count = 0;
         mirror_bound = '0;
         mismatches   = 0;
         pops_seen    = 0;
         drops_seen   = 0;
         ignores_seen = 0;
      endfunction

      // bound of zero (or one past the cells) means the full storage
      function int limit();
         if (mirror_bound == '0 || mirror_bound + 1 > CELLS) return CELLS;
         return mirror_bound + 1;
      endfunction

      // open a slot at the index, shift the tail back, cut to the limit
      function bdq_pkg::rsp_status_type place(int at, logic [bdq_pkg::VALUE_W-1:0] v);
         int i;
         int grown;
         grown = mirror_count + 1;
         for (i = mirror_count; i > at; i--)
            if (i < CELLS) mirror_cells[i] = mirror_cells[i-1];
         if (at < CELLS) mirror_cells[at] = v;
         if (grown > limit()) begin
            mirror_count = limit();
            return bdq_pkg::STS_DROPPED;
         end
         mirror_count = grown;
         return bdq_pkg::STS_DONE;
      endfunction

      function logic [bdq_pkg::VALUE_W-1:0] take(int at);
         logic [bdq_pkg::VALUE_W-1:0] v;
         int i;
         v = mirror_cells[at];
         for (i = at; i + 1 < mirror_count; i++) mirror_cells[i] = mirror_cells[i+1];
         mirror_count--;
         return v;
      endfunction

      function void note_request(logic [bdq_pkg::OPCODE_W-1:0] op,
                                 logic [bdq_pkg::POS_W-1:0] pos,
                                 logic [bdq_pkg::VALUE_W-1:0] v);
         deque_response_type r;
         r.value  = '0;
         r.valid  = 1'b0;
         r.status = bdq_pkg::STS_IGNORED;
         case (op)
            bdq_pkg::OP_PUSH_BACK:  r.status = place(mirror_count, v);
            bdq_pkg::OP_PUSH_FRONT: r.status = place(0, v);
            bdq_pkg::OP_POP_BACK, bdq_pkg::OP_POP_FRONT:
               if (mirror_count > 0) begin
                  r.value  = take(op == bdq_pkg::OP_POP_BACK ? mirror_count - 1 : 0);
                  r.valid  = 1'b1;
                  r.status = bdq_pkg::STS_DONE;
                  pops_seen++;
               end
            bdq_pkg::OP_INSERT:
               if (int'(pos) <= mirror_count) r.status = place(int'(pos), v);
            bdq_pkg::OP_DELETE:
               if (int'(pos) < mirror_count) begin
                  void'(take(int'(pos)));
                  r.status = bdq_pkg::STS_DONE;
               end
            default: ;
         endcase
         if (r.status == bdq_pkg::STS_DROPPED) drops_seen++;
         if (r.status == bdq_pkg::STS_IGNORED) ignores_seen++;
         r.count = mirror_count[bdq_pkg::COUNT_OUT_W-1:0];
         awaited_responses.push_back(r);
      endfunction

      function void compare_field(string what, logic [bdq_pkg::VALUE_W-1:0] want,
                                  logic [bdq_pkg::VALUE_W-1:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                        $time, what, want, got);
         end
      endfunction

      function void check_response(logic [bdq_pkg::VALUE_W-1:0] value, logic valid,
                                   logic [bdq_pkg::COUNT_OUT_W-1:0] count,
                                   logic [bdq_pkg::STATUS_W-1:0] status);
         deque_response_type w;
         if (awaited_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected response word, expected none, actual 0x%0h",
                        $time, {status, count, value});
            return;
         end
         w = awaited_responses.pop_front();
         compare_field("popped_value", w.value, value);
         compare_field("popped_valid", 32'(w.valid), 32'(valid));
         compare_field("entry_count", 32'(w.count), 32'(count));
         compare_field("status", 32'(w.status), 32'(status));
      endfunction
   endclass

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // core ports
   logic                            csr_wr_en;
   logic [bdq_pkg::BOUND_W-1:0]     csr_wr_data;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [bdq_pkg::REQ_TDATA_W-1:0] req_tdata;   // position[4:0], entry_value[36:5]
   logic [bdq_pkg::OPCODE_W-1:0]    req_tuser;   // opcode[2:0]
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [bdq_pkg::RSP_TDATA_W-1:0] rsp_tdata;   // popped_value[31:0], entry_count[36:32],
                                                 // status[38:37]
   logic                            rsp_tuser;   // popped_valid

   bounded_deque_with_indexed_insert_core #(
      .DEPTH (CELLS),
      .WIDTH (bdq_pkg::VALUE_W)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   deque_scoreboard sb;
   bit          tx_gaps_on  = 1'b1;  // sender idles between words
   bit          rx_gaps_on  = 1'b1;  // receiver stalls between words
   bit          rx_hold_req = 1'b0;  // ask the receiver for one long hold-off
   int unsigned words_sent  = 0;
   int unsigned bounds_set  = 0;
   int unsigned quiet_cycles = 0;

   // gap length: mostly none, some short, a few long
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // response side: check on every accepted word (values sampled before the edge)
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata[31:0], rsp_tuser, rsp_tdata[36:32], rsp_tdata[38:37]);
   end

   // watchdog: ends a run in which no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: ready bursts, random stalls, and a long hold-off on request
   initial begin : rsp_sink
      int unsigned n;
      rsp_tready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (rx_hold_req) begin
            // long hold-off so the response register fills and stalls the input
            rx_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         n = rx_gaps_on ? gap_len() : 0;
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   // offer one word, optionally after a gap, and return at the accepting edge
   task automatic send_word(input logic [bdq_pkg::OPCODE_W-1:0] op,
                            input logic [bdq_pkg::POS_W-1:0] pos,
                            input logic [bdq_pkg::VALUE_W-1:0] value);
      int unsigned g;
      g = tx_gaps_on ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, value, pos};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, pos, value);
      words_sent++;
   endtask

   // stop offering and wait until every owed response has been taken
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.awaited_responses.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // bound register is only written with the core drained
   task automatic write_bound(input logic [bdq_pkg::BOUND_W-1:0] b);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= b;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.mirror_bound = b;
      bounds_set++;
   endtask

   // one random word shaped by the traffic mix, with some noise
   task automatic random_word(input traffic_mix_type mix);
      logic [bdq_pkg::OPCODE_W-1:0] op;
      logic [bdq_pkg::POS_W-1:0]    pos;
      logic [bdq_pkg::VALUE_W-1:0]  value;
      int unsigned                  grow_pct;
      int unsigned                  r;
      r = $urandom_range(0, 15);
      value = (r == 0) ? '0 : (r == 1) ? '1 : bdq_pkg::VALUE_W'($urandom);
      pos   = bdq_pkg::POS_W'($urandom);
      if ($urandom_range(0, 99) < 8) begin
         // noise: any opcode, any index
         op = bdq_pkg::OPCODE_W'($urandom_range(0, 7));
      end else begin
         grow_pct = (mix == MIX_FILL) ? 80 : (mix == MIX_DRAIN) ? 20 : 50;
         if ($urandom_range(0, 99) < grow_pct) begin
            r  = $urandom_range(0, 2);
            op = (r == 0) ? bdq_pkg::OP_PUSH_BACK :
                 (r == 1) ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_INSERT;
         end else begin
            r  = $urandom_range(0, 2);
            op = (r == 0) ? bdq_pkg::OP_POP_BACK :
                 (r == 1) ? bdq_pkg::OP_POP_FRONT : bdq_pkg::OP_DELETE;
         end
         // legal index most of the time
         if (op == bdq_pkg::OP_INSERT)
            pos = bdq_pkg::POS_W'($urandom_range(0, sb.mirror_count));
         else if (op == bdq_pkg::OP_DELETE && sb.mirror_count > 0)
            pos = bdq_pkg::POS_W'($urandom_range(0, sb.mirror_count - 1));
      end
      send_word(op, pos, value);
   endtask

   logic [bdq_pkg::BOUND_W-1:0] bound_plan [PHASES] =
      '{4'd15, 4'd3, 4'd0, 4'd7, 4'd1, 4'd12, 4'd2, 4'd0, 4'd15,
        4'd5, 4'd9, 4'd4, 4'd14, 4'd6, 4'd11, 4'd8, 4'd10, 4'd13};

   initial begin : stimulus
      int p;
      int s;
      int k;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = bdq_pkg::OP_PUSH_BACK;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue, bad indexes, spare opcodes
      send_word(bdq_pkg::OP_POP_BACK,   5'd0,  32'h0);
      send_word(bdq_pkg::OP_POP_FRONT,  5'd0,  32'h0);
      send_word(bdq_pkg::OP_DELETE,     5'd0,  32'h0);
      send_word(bdq_pkg::OP_INSERT,     5'd1,  32'h1234_5678);
      send_word(OP_SPARE_A,             5'd0,  32'h0);
      send_word(OP_SPARE_B,             5'd31, 32'hFFFF_FFFF);
      // directed: every operation, insert at the end and in the middle
      send_word(bdq_pkg::OP_PUSH_BACK,  5'd0,  32'hFFFF_FFFF);
      send_word(bdq_pkg::OP_PUSH_FRONT, 5'd0,  32'h0);
      send_word(bdq_pkg::OP_INSERT,     5'd2,  32'hA5A5_A5A5);
      send_word(bdq_pkg::OP_INSERT,     5'd1,  32'h5A5A_5A5A);
      send_word(bdq_pkg::OP_INSERT,     5'd5,  32'h0BAD_0BAD);  // past the end
      send_word(bdq_pkg::OP_DELETE,     5'd4,  32'h0);          // at the count
      send_word(bdq_pkg::OP_DELETE,     5'd1,  32'h0);
      send_word(bdq_pkg::OP_POP_FRONT,  5'd16, 32'h0);
      send_word(bdq_pkg::OP_POP_BACK,   5'd31, 32'h0);
      send_word(bdq_pkg::OP_PUSH_BACK,  5'd0,  32'h1);
      send_word(bdq_pkg::OP_PUSH_BACK,  5'd0,  32'h2);
      // directed: bound lowered under the count, then pushes onto a full queue
      write_bound(4'd1);
      send_word(bdq_pkg::OP_POP_FRONT,  5'd0,  32'h0);          // pops never cut
      send_word(bdq_pkg::OP_PUSH_BACK,  5'd0,  32'h3);          // new entry dropped
      send_word(bdq_pkg::OP_PUSH_FRONT, 5'd0,  32'h4);          // back entry dropped
      send_word(bdq_pkg::OP_INSERT,     5'd2,  32'h5);          // insert at the end
      send_word(bdq_pkg::OP_INSERT,     5'd1,  32'h6);
      send_word(bdq_pkg::OP_DELETE,     5'd0,  32'h0);

      // random phases, one bound setting each
      for (p = 0; p < PHASES; p++) begin
         write_bound(bound_plan[p]);
         tx_gaps_on = (p % 4 != 2);
         rx_gaps_on = (p % 4 != 2) && (p % 4 != 3);
         for (s = 0; s < SEGMENTS; s++) begin
            // receiver backs up while the sender keeps offering
            if ((p == 3 || p == 11) && s == 1) rx_hold_req = 1'b1;
            for (k = 0; k < SEGMENT_WORDS; k++)
               random_word(traffic_mix_type'($urandom_range(0, 2)));
         end
         // sender pause until the core has handed back everything
         if (p == 6) wait_idle();
      end

      wait_idle();
      repeat (4) @(posedge clock);
      $display("covered %0d request words over %0d bound settings", words_sent, bounds_set);
      $display("pops %0d, drops by bound %0d, ignored words %0d",
               sb.pops_seen, sb.drops_seen, sb.ignores_seen);
      if (sb.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
